// ----- sv/fjr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and reset values for the feeder jam recovery block
package fjr_pkg;

    // counter width default
    localparam int COUNT_WIDTH_DEF = 16;

    // config port geometry
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_INDEX_W = 3;

    // config field widths
    localparam int THRESH_W  = 15;
    localparam int TICKS_W   = 16;
    localparam int BACKOFF_W = 19;

    // config reset values
    localparam logic [THRESH_W-1:0]  THRESH_RST   = 15'd8000;
    localparam logic [TICKS_W-1:0]   SUSPECT_RST  = 16'd100;
    localparam logic [TICKS_W-1:0]   RECOVER_RST  = 16'd200;
    localparam logic [TICKS_W-1:0]   STUCK_RST    = 16'd400;
    localparam logic [TICKS_W-1:0]   COOLDOWN_RST = 16'd1000;
    localparam logic [BACKOFF_W-1:0] BACKOFF_RST  = 19'd45752;  // 2*pi/9 in q16.16

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESH   = 3'd0,
        REG_SUSPECT  = 3'd1,
        REG_RECOVER  = 3'd2,
        REG_STUCK    = 3'd3,
        REG_COOLDOWN = 3'd4,
        REG_BACKOFF  = 3'd5
    } reg_index_t;

    // reported mode codes
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_SUSPECT  = 3'd1;
    localparam logic [2:0] MODE_JAM      = 3'd2;
    localparam logic [2:0] MODE_BACKOFF  = 3'd3;
    localparam logic [2:0] MODE_DISABLED = 3'd4;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_MOVE    = 2'd1,
        ACT_DISABLE = 2'd2,
        ACT_HOLD    = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [15:0] torque;
        logic signed [31:0] position;
    } in_t;

    typedef struct packed {
        logic [2:0]         mode;
        action_t            action;
        logic signed [31:0] target_angle;
    } out_t;

    typedef struct packed {
        logic [THRESH_W-1:0]  torque_threshold;
        logic [TICKS_W-1:0]   suspect_ticks;
        logic [TICKS_W-1:0]   recover_ticks;
        logic [TICKS_W-1:0]   stuck_ticks;
        logic [TICKS_W-1:0]   cooldown_ticks;
        logic [BACKOFF_W-1:0] backoff_angle;
    } cfg_t;

endpackage

// ----- sv/fjr_cfg_regs.sv -----
`timescale 1ns / 1ps
// apb configuration register file
module fjr_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fjr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fjr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fjr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output fjr_pkg::cfg_t                  cfg
);

    fjr_pkg::cfg_t      cfg_reg;
    fjr_pkg::reg_index_t idx;
    logic               wr_en;

    assign idx    = fjr_pkg::reg_index_t'(paddr[fjr_pkg::CFG_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.torque_threshold <= fjr_pkg::THRESH_RST;
            cfg_reg.suspect_ticks    <= fjr_pkg::SUSPECT_RST;
            cfg_reg.recover_ticks    <= fjr_pkg::RECOVER_RST;
            cfg_reg.stuck_ticks      <= fjr_pkg::STUCK_RST;
            cfg_reg.cooldown_ticks   <= fjr_pkg::COOLDOWN_RST;
            cfg_reg.backoff_angle    <= fjr_pkg::BACKOFF_RST;
        end else if (wr_en) begin
            case (idx)
                fjr_pkg::REG_THRESH:   cfg_reg.torque_threshold <= pwdata[14:0];
                fjr_pkg::REG_SUSPECT:  cfg_reg.suspect_ticks    <= pwdata[15:0];
                fjr_pkg::REG_RECOVER:  cfg_reg.recover_ticks    <= pwdata[15:0];
                fjr_pkg::REG_STUCK:    cfg_reg.stuck_ticks      <= pwdata[15:0];
                fjr_pkg::REG_COOLDOWN: cfg_reg.cooldown_ticks   <= pwdata[15:0];
                fjr_pkg::REG_BACKOFF:  cfg_reg.backoff_angle    <= pwdata[18:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            fjr_pkg::REG_THRESH:   prdata = 32'(cfg_reg.torque_threshold);
            fjr_pkg::REG_SUSPECT:  prdata = 32'(cfg_reg.suspect_ticks);
            fjr_pkg::REG_RECOVER:  prdata = 32'(cfg_reg.recover_ticks);
            fjr_pkg::REG_STUCK:    prdata = 32'(cfg_reg.stuck_ticks);
            fjr_pkg::REG_COOLDOWN: prdata = 32'(cfg_reg.cooldown_ticks);
            fjr_pkg::REG_BACKOFF:  prdata = 32'(cfg_reg.backoff_angle);
            default:               prdata = '0;
        endcase
    end

endmodule

// ----- sv/fjr_core.sv -----
`timescale 1ns / 1ps
// jam detection state machine, run counters and result logic
module fjr_core #(
    parameter int COUNT_WIDTH = fjr_pkg::COUNT_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  fjr_pkg::cfg_t cfg,
    input  fjr_pkg::in_t  req,
    output fjr_pkg::out_t res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_NORMAL   = fjr_pkg::MODE_NORMAL,
        ST_SUSPECT  = fjr_pkg::MODE_SUSPECT,
        ST_JAM      = fjr_pkg::MODE_JAM,
        ST_BACKOFF  = fjr_pkg::MODE_BACKOFF,
        ST_DISABLED = fjr_pkg::MODE_DISABLED
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] mode_ticks_reg, mode_ticks_next;
    logic [COUNT_WIDTH-1:0] low_run_reg, low_run_next;
    logic [COUNT_WIDTH-1:0] high_run_reg, high_run_next;
    logic [COUNT_WIDTH-1:0] cool_reg, cool_next;

    logic [16:0]            t_ext;
    logic [16:0]            mag;
    logic                   high;
    logic [COUNT_WIDTH-1:0] mt_inc, lo_inc, hi_inc, cool_inc;
    logic [COUNT_WIDTH-1:0] lo_tmp, hi_tmp;

    assign t_ext  = {req.torque[15], req.torque};
    assign mag    = t_ext[16] ? (~t_ext + 17'd1) : t_ext;
    assign high   = mag >= {2'b00, cfg.torque_threshold};

    assign mt_inc   = (mode_ticks_reg == CNT_MAX) ? CNT_MAX : mode_ticks_reg + 1'b1;
    assign lo_inc   = (low_run_reg == CNT_MAX) ? CNT_MAX : low_run_reg + 1'b1;
    assign hi_inc   = (high_run_reg == CNT_MAX) ? CNT_MAX : high_run_reg + 1'b1;
    assign cool_inc = (cool_reg == CNT_MAX) ? CNT_MAX : cool_reg + 1'b1;

    always_comb begin
        state_next      = state_reg;
        mode_ticks_next = mt_inc;
        low_run_next    = low_run_reg;
        high_run_next   = high_run_reg;
        cool_next       = cool_reg;
        lo_tmp          = '0;
        hi_tmp          = '0;
        res.action       = fjr_pkg::ACT_NONE;
        res.target_angle = '0;
        case (state_reg)
            ST_NORMAL: begin
                if (high) begin
                    state_next      = ST_SUSPECT;
                    mode_ticks_next = '0;
                end
            end
            ST_SUSPECT: begin
                if (32'(mt_inc) >= 32'(cfg.suspect_ticks)) begin
                    state_next      = ST_JAM;
                    mode_ticks_next = '0;
                end else if (!high) begin
                    state_next      = ST_NORMAL;
                    mode_ticks_next = '0;
                end
            end
            ST_JAM: begin
                res.action       = fjr_pkg::ACT_MOVE;
                res.target_angle = req.position - $signed(32'(cfg.backoff_angle));
                state_next       = ST_BACKOFF;
                mode_ticks_next  = '0;
            end
            ST_BACKOFF: begin
                lo_tmp        = high ? '0 : lo_inc;
                hi_tmp        = high ? hi_inc : '0;
                low_run_next  = lo_tmp;
                high_run_next = hi_tmp;
                if (32'(lo_tmp) >= 32'(cfg.recover_ticks)) begin
                    low_run_next    = '0;
                    state_next      = ST_NORMAL;
                    mode_ticks_next = '0;
                end
                // stuck check wins over recovery
                if (32'(hi_tmp) >= 32'(cfg.stuck_ticks)) begin
                    high_run_next   = '0;
                    state_next      = ST_DISABLED;
                    mode_ticks_next = '0;
                end
            end
            ST_DISABLED: begin
                res.action = fjr_pkg::ACT_DISABLE;
                cool_next  = cool_inc;
                if (32'(cool_inc) > 32'(cfg.cooldown_ticks) && !high) begin
                    res.action       = fjr_pkg::ACT_HOLD;
                    res.target_angle = req.position;
                    cool_next        = '0;
                    state_next       = ST_SUSPECT;
                    mode_ticks_next  = '0;
                end
            end
            default: begin
                if (high) begin
                    state_next      = ST_SUSPECT;
                    mode_ticks_next = '0;
                end else begin
                    state_next = ST_NORMAL;
                end
            end
        endcase
        res.mode = state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_NORMAL;
            mode_ticks_reg <= '0;
            low_run_reg    <= '0;
            high_run_reg   <= '0;
            cool_reg       <= '0;
        end else if (step) begin
            state_reg      <= state_next;
            mode_ticks_reg <= mode_ticks_next;
            low_run_reg    <= low_run_next;
            high_run_reg   <= high_run_next;
            cool_reg       <= cool_next;
        end
    end

endmodule

// ----- sv/feeder_jam_recovery_fsm.sv -----
`timescale 1ns / 1ps
// top level of the feeder jam detector and recovery controller
//
// Feeder jam detector: each request carries one control tick (signed torque
// sample and q16.16 motor position) and produces exactly one result (mode,
// action, target angle). A request is captured in an input register, the
// state machine and its saturating counters evaluate it in one pass of
// short logic, and the result lands in an output register. Throughput is one
// request per clock while the input side is not stalled. The
// input side keeps accepting while a finished result waits, and only stalls
// when both registers are full and m_ready is low. Thresholds and the back-off
// angle sit in an apb register file (byte addresses 4*index) and should only
// be written while no request is in flight. Counters saturate at
// 2^COUNT_WIDTH - 1; the back-off target wraps modulo 2^32.
module feeder_jam_recovery_fsm #(
    parameter int COUNT_WIDTH = fjr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fjr_pkg::in_t                   s_payload,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output fjr_pkg::out_t                  m_payload,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fjr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fjr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fjr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    fjr_pkg::cfg_t cfg;
    fjr_pkg::out_t res;

    // input stage
    logic          in_valid_reg;
    fjr_pkg::in_t  in_data_reg;
    // output stage
    logic          out_valid_reg;
    fjr_pkg::out_t out_data_reg;

    // a request moves on when the output slot is free or being drained
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    fjr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state only moves when the request leaves the input register
    fjr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg),
        .req     (in_data_reg),
        .res     (res)
    );

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_payload;
        end
        if (advance) begin
            out_data_reg <= res;
        end
    end

`ifndef SYNTHESIS
    // a move command only comes with the step into backing off
    a_move_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.action == fjr_pkg::ACT_MOVE
        |-> m_payload.mode == fjr_pkg::MODE_BACKOFF)
        else $error("move action outside back-off");

    // re-arm always lands in suspect
    a_hold_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.action == fjr_pkg::ACT_HOLD
        |-> m_payload.mode == fjr_pkg::MODE_SUSPECT)
        else $error("hold action outside suspect");

    // a plain disable keeps the drive off
    a_disable_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.action == fjr_pkg::ACT_DISABLE
        |-> m_payload.mode == fjr_pkg::MODE_DISABLED)
        else $error("disable action outside disabled mode");

    // input side only stalls when both stages are full and output is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("request side stalled without cause");
`endif

endmodule
